FILE: design/assert_macros.svh
// Assertion helpers shared by the running median block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMTH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("running median check failed");

// Next-cycle implication, checked outside reset.
`define RMTH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("running median check failed");

`endif

FILE: design/rmth_pkg.sv
`timescale 1ns / 1ps

package rmth_pkg;

  // Default sizes of the block.
  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int SAMPLE_W       = 32;

  // Where a pushed value comes from.
  typedef enum logic [1:0] {
    SRC_SAMPLE,
    SRC_LTOP,
    SRC_UTOP
  } src_t;

  // Micro-operations the datapath executes for the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_PUSH_INIT,
    DP_PUSH_STEP,
    DP_PUSH_CMP,
    DP_POP_INIT,
    DP_POP_LAST,
    DP_POP_CHK,
    DP_POP_L,
    DP_POP_R,
    DP_FINISH
  } dp_op_t;

  // One heap operation of an item's plan.
  typedef struct packed {
    logic is_pop;
    logic upper;
    src_t src;
  } plan_t;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_t op;
    logic   upper;
    src_t   src;
    logic   ovf;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic eq;
    logic lgt;
    logic greater;
    logic full;
    logic done;
    logic r_in;
  } dp_stat_t;

endpackage

FILE: design/rmth_ram.sv
`timescale 1ns / 1ps

module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/rmth_controller.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmth_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output rmth_pkg::dp_cmd_t  cmd,
  input  rmth_pkg::dp_stat_t stat
);

  import rmth_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_OPSTART,
    S_PUSH_STEP,
    S_PUSH_CMP,
    S_POP_LAST,
    S_POP_CHK,
    S_POP_L,
    S_POP_R,
    S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  plan_t      plan_r [3];
  plan_t      plan_nxt [3];
  logic [1:0] nops_r, nops_nxt;
  logic [1:0] cur_r, cur_nxt;
  logic       ovf_r, ovf_nxt;
  state_t     after_op;

  // After an operation completes, start the next one or finish the item.
  assign after_op = ((cur_r + 2'd1) == nops_r) ? S_FINISH : S_OPSTART;
  assign busy     = (state_r != S_IDLE);

  // Next state, plan and command to the datapath.
  always_comb begin
    state_nxt = state_r;
    plan_nxt  = plan_r;
    nops_nxt  = nops_r;
    cur_nxt   = cur_r;
    ovf_nxt   = ovf_r;
    cmd.op    = DP_NOP;
    cmd.upper = plan_r[cur_r].upper;
    cmd.src   = plan_r[cur_r].src;
    cmd.ovf   = ovf_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = DP_LOAD;
          ovf_nxt   = 1'b0;
          cur_nxt   = 2'd0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_OPSTART;
        if (stat.eq) begin
          // Equal sizes: the sample goes to one heap, or is dropped when full.
          if (stat.full) begin
            ovf_nxt   = 1'b1;
            nops_nxt  = 2'd0;
            state_nxt = S_FINISH;
          end else begin
            plan_nxt[0] = '{is_pop: 1'b0, upper: stat.greater, src: SRC_SAMPLE};
            nops_nxt    = 2'd1;
          end
        end else if (stat.lgt) begin
          if (stat.greater) begin
            plan_nxt[0] = '{is_pop: 1'b0, upper: 1'b1, src: SRC_SAMPLE};
            nops_nxt    = 2'd1;
          end else begin
            // Move the lower top across, then insert the sample below.
            plan_nxt[0] = '{is_pop: 1'b0, upper: 1'b1, src: SRC_LTOP};
            plan_nxt[1] = '{is_pop: 1'b1, upper: 1'b0, src: SRC_SAMPLE};
            plan_nxt[2] = '{is_pop: 1'b0, upper: 1'b0, src: SRC_SAMPLE};
            nops_nxt    = 2'd3;
          end
        end else begin
          if (stat.greater) begin
            // Move the upper top across, then insert the sample above.
            plan_nxt[0] = '{is_pop: 1'b0, upper: 1'b0, src: SRC_UTOP};
            plan_nxt[1] = '{is_pop: 1'b1, upper: 1'b1, src: SRC_SAMPLE};
            plan_nxt[2] = '{is_pop: 1'b0, upper: 1'b1, src: SRC_SAMPLE};
            nops_nxt    = 2'd3;
          end else begin
            plan_nxt[0] = '{is_pop: 1'b0, upper: 1'b0, src: SRC_SAMPLE};
            nops_nxt    = 2'd1;
          end
        end
      end
      S_OPSTART: begin
        if (plan_r[cur_r].is_pop) begin
          cmd.op    = DP_POP_INIT;
          state_nxt = S_POP_LAST;
        end else begin
          cmd.op    = DP_PUSH_INIT;
          state_nxt = S_PUSH_STEP;
        end
      end
      S_PUSH_STEP: begin
        cmd.op = DP_PUSH_STEP;
        if (stat.done) begin
          cur_nxt   = cur_r + 2'd1;
          state_nxt = after_op;
        end else begin
          state_nxt = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        cmd.op = DP_PUSH_CMP;
        if (stat.done) begin
          cur_nxt   = cur_r + 2'd1;
          state_nxt = after_op;
        end else begin
          state_nxt = S_PUSH_STEP;
        end
      end
      S_POP_LAST: begin
        cmd.op    = DP_POP_LAST;
        state_nxt = S_POP_CHK;
      end
      S_POP_CHK: begin
        cmd.op = DP_POP_CHK;
        if (stat.done) begin
          cur_nxt   = cur_r + 2'd1;
          state_nxt = after_op;
        end else begin
          state_nxt = S_POP_L;
        end
      end
      S_POP_L: begin
        cmd.op = DP_POP_L;
        if (stat.done) begin
          cur_nxt   = cur_r + 2'd1;
          state_nxt = after_op;
        end else if (stat.r_in) begin
          state_nxt = S_POP_R;
        end else begin
          state_nxt = S_POP_CHK;
        end
      end
      S_POP_R: begin
        cmd.op = DP_POP_R;
        if (stat.done) begin
          cur_nxt   = cur_r + 2'd1;
          state_nxt = after_op;
        end else begin
          state_nxt = S_POP_CHK;
        end
      end
      S_FINISH: begin
        cmd.op    = DP_FINISH;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and plan registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nops_r  <= 2'd0;
      cur_r   <= 2'd0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nops_r  <= nops_nxt;
      cur_r   <= cur_nxt;
      ovf_r   <= ovf_nxt;
    end
    plan_r <= plan_nxt;
  end

  `RMTH_ASSERT_NXT(a_finish_to_idle, state_r == S_FINISH, state_r == S_IDLE)
  `RMTH_ASSERT_NXT(a_full_drops, state_r == S_DECIDE && stat.eq && stat.full,
                   state_r == S_FINISH && ovf_r)

endmodule

FILE: design/rmth_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmth_datapath #(
  parameter int HEAP_DEPTH = rmth_pkg::HEAP_DEPTH_DEF,
  parameter int DATA_WIDTH = rmth_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rmth_pkg::dp_cmd_t                    cmd,
  output rmth_pkg::dp_stat_t                   stat,
  input  logic signed [rmth_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last,
  output logic                                 out_valid,
  output logic signed [rmth_pkg::SAMPLE_W-1:0] out_median,
  output logic                                 out_overflow
);

  import rmth_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int XW = AW + 2;
  localparam int DW = DATA_WIDTH;

  logic signed [DW-1:0] smp_r, smp_nxt;
  logic signed [DW-1:0] v_r, v_nxt;
  logic signed [DW-1:0] cand_r, cand_nxt;
  logic signed [DW-1:0] ltop_r, ltop_nxt;
  logic signed [DW-1:0] utop_r, utop_nxt;
  logic signed [DW-1:0] med_r, med_nxt;
  logic                 last_r, last_nxt;
  logic                 bestl_r, bestl_nxt;
  logic [AW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        lcnt_r, lcnt_nxt;
  logic [CW-1:0]        ucnt_r, ucnt_nxt;
  logic                 ovld_r, ovld_nxt;
  logic signed [SAMPLE_W-1:0] omed_r, omed_nxt;
  logic                 oovf_r, oovf_nxt;

  logic                 l_we, u_we, we;
  logic [AW-1:0]        waddr, raddr;
  logic signed [DW-1:0] wdata;
  logic [DW-1:0]        lrd, urd;
  logic signed [DW-1:0] rdata, srcval, bestval;
  logic [CW-1:0]        cnt_sel, cnt_dec;
  logic [AW-1:0]        parent;
  logic [XW-1:0]        l_x, r_x, n_x;
  logic                 l_in, r_in, is_max;
  logic signed [DW:0]   sum, adj;
  logic signed [DW-1:0] mid, med_new;
  logic                 st_done, st_r_in;

  // True when a must sit above b in the selected heap.
  function automatic logic above(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                                 logic mx);
    above = mx ? (a > b) : (a < b);
  endfunction

  // Heap storage: lower half is a max-heap, upper half a min-heap.
  rmth_ram #(.WIDTH(DW), .DEPTH(HEAP_DEPTH)) u_lower_ram (
    .clk(clk), .we(l_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(lrd)
  );

  rmth_ram #(.WIDTH(DW), .DEPTH(HEAP_DEPTH)) u_upper_ram (
    .clk(clk), .we(u_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(urd)
  );

  // Index arithmetic of the heap in use.
  assign is_max  = !cmd.upper;
  assign rdata   = cmd.upper ? signed'(urd) : signed'(lrd);
  assign cnt_sel = cmd.upper ? ucnt_r : lcnt_r;
  assign cnt_dec = cnt_sel - CW'(1);
  assign parent  = (i_r - AW'(1)) >> 1;
  assign l_x     = {1'b0, i_r, 1'b1};
  assign r_x     = l_x + XW'(1);
  assign n_x     = XW'(n_r);
  assign l_in    = (l_x < n_x);
  assign r_in    = (r_x < n_x);
  assign l_we    = we && !cmd.upper;
  assign u_we    = we && cmd.upper;

  // Value pushed by a push operation.
  always_comb begin
    case (cmd.src)
      SRC_LTOP: srcval = ltop_r;
      SRC_UTOP: srcval = utop_r;
      default:  srcval = smp_r;
    endcase
  end

  // Median from the tops: the larger heap's top, or the halved sum of both.
  assign sum = (DW + 1)'(ltop_r) + (DW + 1)'(utop_r);
  assign adj = sum[DW] ? sum + (DW + 1)'(1) : sum;
  assign mid = adj[DW:1];
  always_comb begin
    if (lcnt_r == ucnt_r) begin
      med_new = mid;
    end else if (lcnt_r > ucnt_r) begin
      med_new = ltop_r;
    end else begin
      med_new = utop_r;
    end
  end

  // Status for the controller.
  assign stat.eq      = (lcnt_r == ucnt_r);
  assign stat.lgt     = (lcnt_r > ucnt_r);
  assign stat.greater = (smp_r > med_r);
  assign stat.full    = (lcnt_r == CW'(HEAP_DEPTH));
  assign stat.done    = st_done;
  assign stat.r_in    = st_r_in;

  // Micro-operation execution.
  always_comb begin
    smp_nxt   = smp_r;
    last_nxt  = last_r;
    v_nxt     = v_r;
    cand_nxt  = cand_r;
    bestl_nxt = bestl_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    lcnt_nxt  = lcnt_r;
    ucnt_nxt  = ucnt_r;
    med_nxt   = med_r;
    ovld_nxt  = 1'b0;
    omed_nxt  = omed_r;
    oovf_nxt  = oovf_r;
    we        = 1'b0;
    waddr     = i_r;
    wdata     = v_r;
    raddr     = '0;
    bestval   = bestl_r ? cand_r : v_r;
    st_done   = 1'b0;
    st_r_in   = 1'b0;
    case (cmd.op)
      DP_LOAD: begin
        smp_nxt  = sample[DW-1:0];
        last_nxt = last;
      end
      DP_PUSH_INIT: begin
        v_nxt = srcval;
        i_nxt = cnt_sel[AW-1:0];
        if (cmd.upper) begin
          ucnt_nxt = ucnt_r + CW'(1);
        end else begin
          lcnt_nxt = lcnt_r + CW'(1);
        end
      end
      DP_PUSH_STEP: begin
        if (i_r == '0) begin
          we      = 1'b1;
          st_done = 1'b1;
        end else begin
          raddr = parent;
        end
      end
      DP_PUSH_CMP: begin
        we = 1'b1;
        if (above(v_r, rdata, is_max)) begin
          wdata = rdata;
          i_nxt = parent;
        end else begin
          st_done = 1'b1;
        end
      end
      DP_POP_INIT: begin
        n_nxt = cnt_dec;
        i_nxt = '0;
        raddr = cnt_dec[AW-1:0];
        if (cmd.upper) begin
          ucnt_nxt = cnt_dec;
        end else begin
          lcnt_nxt = cnt_dec;
        end
      end
      DP_POP_LAST: begin
        v_nxt = rdata;
      end
      DP_POP_CHK: begin
        if (l_in) begin
          raddr = l_x[AW-1:0];
        end else begin
          we      = 1'b1;
          st_done = 1'b1;
        end
      end
      DP_POP_L: begin
        cand_nxt  = rdata;
        bestl_nxt = above(rdata, v_r, is_max);
        if (r_in) begin
          raddr   = r_x[AW-1:0];
          st_r_in = 1'b1;
        end else begin
          we = 1'b1;
          if (above(rdata, v_r, is_max)) begin
            wdata = rdata;
            i_nxt = l_x[AW-1:0];
          end else begin
            st_done = 1'b1;
          end
        end
      end
      DP_POP_R: begin
        we = 1'b1;
        if (above(rdata, bestval, is_max)) begin
          wdata = rdata;
          i_nxt = r_x[AW-1:0];
        end else if (bestl_r) begin
          wdata = cand_r;
          i_nxt = l_x[AW-1:0];
        end else begin
          st_done = 1'b1;
        end
      end
      DP_FINISH: begin
        ovld_nxt = 1'b1;
        oovf_nxt = cmd.ovf;
        omed_nxt = cmd.ovf ? SAMPLE_W'(med_r) : SAMPLE_W'(med_new);
        if (!cmd.ovf) begin
          med_nxt = med_new;
        end
        if (last_r) begin
          lcnt_nxt = '0;
          ucnt_nxt = '0;
          med_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Cached heap tops follow every write to the root.
  always_comb begin
    ltop_nxt = ltop_r;
    utop_nxt = utop_r;
    if (l_we && waddr == '0) begin
      ltop_nxt = wdata;
    end
    if (u_we && waddr == '0) begin
      utop_nxt = wdata;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
      ucnt_r <= '0;
      med_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      lcnt_r <= lcnt_nxt;
      ucnt_r <= ucnt_nxt;
      med_r  <= med_nxt;
      ovld_r <= ovld_nxt;
    end
    smp_r   <= smp_nxt;
    last_r  <= last_nxt;
    v_r     <= v_nxt;
    cand_r  <= cand_nxt;
    bestl_r <= bestl_nxt;
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    ltop_r  <= ltop_nxt;
    utop_r  <= utop_nxt;
    omed_r  <= omed_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_valid    = ovld_r;
  assign out_median   = omed_r;
  assign out_overflow = oovf_r;

  `RMTH_ASSERT_IMP(a_heaps_balanced, 1'b1,
                   lcnt_r == ucnt_r || (lcnt_r - ucnt_r) == CW'(1) ||
                   (ucnt_r - lcnt_r) == CW'(1))

endmodule

FILE: design/running_median_two_heaps.sv
// When a sample is dropped, the result strobe follows start via S_DECIDE and S_FINISH;
// when a top moves across, it follows a push, a pop and a push. A new item is taken only after
// busy falls. Each heap level steps through S_PUSH_STEP and S_PUSH_CMP on a push and through
// S_POP_CHK, S_POP_L and S_POP_R on a pop, set by the single registered read port of each heap memory.
// The result strobe is one cycle wide and cannot be stalled; busy falls in that cycle.
// Synchronous reset empties both heaps and clears the median; no memory clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module running_median_two_heaps #(
  parameter int HEAP_DEPTH = rmth_pkg::HEAP_DEPTH_DEF,
  parameter int DATA_WIDTH = rmth_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rmth_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_last_in_sequence,
  output logic                                 out_valid,
  output logic signed [rmth_pkg::SAMPLE_W-1:0] out_median_value,
  output logic                                 out_overflow
);

  import rmth_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer of heap operations.
  rmth_controller u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  // Heap memories, counts, median and result register.
  rmth_datapath #(.HEAP_DEPTH(HEAP_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .sample(in_sample), .last(in_last_in_sequence),
    .out_valid(out_valid), .out_median(out_median_value), .out_overflow(out_overflow)
  );

  `RMTH_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `RMTH_ASSERT_IMP(a_result_idle, out_valid, !busy)

endmodule
